/* sv/swb_pkg.sv */
// ----------------------------------------------------------------------------
// swb_pkg
// shared sizes, state encoding and the command and status bundles
// that pass between the controller and the datapath of the write buffer
// ----------------------------------------------------------------------------
package swb_pkg;

   localparam int DEPTH  = 32;
   localparam int KEY_W  = 64;
   localparam int VAL_W  = 64;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_INSERT
   } swb_state_type;

   // controller to datapath
   typedef struct packed {
      logic insert;     // sorted insert this cycle
      logic use_pend;   // insert takes the held word instead of the request
      logic hold;       // capture the request word
      logic fwd_load;   // load the request word into the output register
      logic drain_step; // move slot zero out and shift the store down
   } swb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic one;
      logic full;
      logic out_free;
   } swb_stat_type;

endpackage

/* sv/sorted_write_buffer_top.sv */
// ----------------------------------------------------------------------------
// sorted_write_buffer_top
// write buffer holding key and value pairs sorted by key, drained in order
//
//   channel  ports                          direction  carries
//   req      req_valid/ready, cmd,key,value in         insert or flush word
//   rsp      rsp_valid/ready, out_key,...   out        drained or forwarded pair
//   csr      csr_valid/ready, buffer_enable in         enable register write
//
// an insert into a buffer that is not full, or a forward, stays in idle, and a new
// word can be taken the next cycle if the output register is free; a drain sends
// one entry per accepted result, and an insert into a full buffer drains it and
// then inserts the held word; the request side is held off during both and while
// a result waits and cannot be taken; reset is synchronous and clears count and control
// ----------------------------------------------------------------------------
module sorted_write_buffer_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [swb_pkg::KEY_W-1:0]  req_key,
   input  logic [swb_pkg::VAL_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [swb_pkg::KEY_W-1:0]  rsp_out_key,
   output logic [swb_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_buffer_enable
);
   import swb_pkg::*;

   swb_cmd_type  cmd;
   swb_stat_type stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // controller
   swb_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .csr_valid         (csr_valid),
      .csr_buffer_enable (csr_buffer_enable),
      .stat              (stat),
      .cmd               (cmd)
   );

   // datapath
   swb_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule

/* sv/swb_ctrl.sv */
// ----------------------------------------------------------------------------
// swb_ctrl
// controller: enable register, request decode and the drain sequence
// ----------------------------------------------------------------------------
module swb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic                  csr_valid,
   input  logic                  csr_buffer_enable,
   input  swb_pkg::swb_stat_type stat,
   output swb_pkg::swb_cmd_type  cmd
);
   import swb_pkg::*;

   swb_state_type state_ff, state_in;
   logic          enable_ff, enable_in;
   logic          pend_ff, pend_in;
   logic          accept;

   assign accept = req_valid && req_ready;

   // enable register and pending-insert flag
   always_comb begin
      enable_in = enable_ff;
      if (csr_valid) begin
         enable_in = csr_buffer_enable;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = enable_ff && (req_cmd == CMD_INSERT) && stat.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         enable_ff <= 1'b1;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         enable_ff <= enable_in;
         pend_ff   <= pend_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && enable_ff) begin
               if (req_cmd == CMD_FLUSH) begin
                  if (!stat.empty) begin
                     state_in = ST_DRAIN;
                  end
               end else if (stat.full) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (stat.out_free && stat.one) begin
               state_in = pend_ff ? ST_INSERT : ST_IDLE;
            end
         end
         ST_INSERT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            cmd.hold  = accept;
            if (accept) begin
               if (!enable_ff) begin
                  cmd.fwd_load = (req_cmd == CMD_INSERT);
               end else if (req_cmd == CMD_INSERT && !stat.full) begin
                  cmd.insert = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            cmd.drain_step = stat.out_free;
         end
         ST_INSERT: begin
            cmd.insert   = 1'b1;
            cmd.use_pend = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* sv/swb_dp.sv */
// ----------------------------------------------------------------------------
// swb_dp
// datapath: sorted key and value store with parallel compare and shift,
// entry count, held request word and the output register
// ----------------------------------------------------------------------------
module swb_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  swb_pkg::swb_cmd_type       cmd,
   output swb_pkg::swb_stat_type      stat,
   input  logic [swb_pkg::KEY_W-1:0]  req_key,
   input  logic [swb_pkg::VAL_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [swb_pkg::KEY_W-1:0]  rsp_out_key,
   output logic [swb_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                       rsp_last
);
   import swb_pkg::*;

   logic [KEY_W-1:0] key_ff [DEPTH];
   logic [KEY_W-1:0] key_in [DEPTH];
   logic [VAL_W-1:0] val_ff [DEPTH];
   logic [VAL_W-1:0] val_in [DEPTH];
   logic [KEY_W-1:0] up_key [DEPTH];
   logic [VAL_W-1:0] up_val [DEPTH];
   logic [KEY_W-1:0] dn_key [DEPTH];
   logic [VAL_W-1:0] dn_val [DEPTH];
   logic [DEPTH-1:0] lt, eq, at_pos;
   logic             any_eq;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] pend_key_ff;
   logic [VAL_W-1:0] pend_val_ff;
   logic [KEY_W-1:0] ins_key;
   logic [VAL_W-1:0] ins_val;

   logic             out_valid_ff, out_valid_in;
   logic [KEY_W-1:0] out_key_ff, out_key_in;
   logic [VAL_W-1:0] out_val_ff, out_val_in;
   logic             out_last_ff, out_last_in;

   // status
   assign stat.empty    = (count_ff == '0);
   assign stat.one      = (count_ff == CNT_W'(1));
   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.out_free = !out_valid_ff || rsp_ready;

   assign ins_key = cmd.use_pend ? pend_key_ff : req_key;
   assign ins_val = cmd.use_pend ? pend_val_ff : req_value;
   assign any_eq  = |eq;

   // per-slot compare and neighbor taps
   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      assign lt[i] = (CNT_W'(i) < count_ff) && (key_ff[i] < ins_key);
      assign eq[i] = (CNT_W'(i) < count_ff) && (key_ff[i] == ins_key);
      if (i == 0) begin : g_first
         assign at_pos[i] = !lt[i];
         assign up_key[i] = ins_key;
         assign up_val[i] = ins_val;
      end else begin : g_rest
         assign at_pos[i] = !lt[i] && lt[i-1];
         assign up_key[i] = key_ff[i-1];
         assign up_val[i] = val_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_top
         assign dn_key[i] = key_ff[i];
         assign dn_val[i] = val_ff[i];
      end else begin : g_low
         assign dn_key[i] = key_ff[i+1];
         assign dn_val[i] = val_ff[i+1];
      end

      // slot next value
      always_comb begin
         key_in[i] = key_ff[i];
         val_in[i] = val_ff[i];
         if (cmd.drain_step) begin
            key_in[i] = dn_key[i];
            val_in[i] = dn_val[i];
         end else if (cmd.insert) begin
            if (any_eq) begin
               if (eq[i]) begin
                  val_in[i] = ins_val;
               end
            end else if (at_pos[i]) begin
               key_in[i] = ins_key;
               val_in[i] = ins_val;
            end else if (!lt[i]) begin
               key_in[i] = up_key[i];
               val_in[i] = up_val[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         key_ff[i] <= key_in[i];
         val_ff[i] <= val_in[i];
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.drain_step) begin
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.insert && !any_eq) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_key_in   = out_key_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      if (cmd.fwd_load) begin
         out_valid_in = 1'b1;
         out_key_in   = req_key;
         out_val_in   = req_value;
         out_last_in  = 1'b1;
      end else if (cmd.drain_step) begin
         out_valid_in = 1'b1;
         out_key_in   = key_ff[0];
         out_val_in   = val_ff[0];
         out_last_in  = stat.one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // held word and output payload
   always_ff @(posedge clock) begin
      if (cmd.hold) begin
         pend_key_ff <= req_key;
         pend_val_ff <= req_value;
      end
      out_key_ff  <= out_key_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_key   = out_key_ff;
   assign rsp_out_value = out_val_ff;
   assign rsp_last      = out_last_ff;

endmodule

/* test/swb_checker.sv */
// ----------------------------------------------------------------------------
// swb_checker
// watches the request, result and register channels of the write buffer,
// keeps its own sorted store and compares each drained or forwarded pair
// ----------------------------------------------------------------------------
module swb_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [swb_pkg::KEY_W-1:0]  req_key,
   input  logic [swb_pkg::VAL_W-1:0]  req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [swb_pkg::KEY_W-1:0]  rsp_out_key,
   input  logic [swb_pkg::VAL_W-1:0]  rsp_out_value,
   input  logic                       rsp_last,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic                       csr_buffer_enable,
   output int                         fail_count,
   output int                         pending
);
   import swb_pkg::*;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic             last;
   } pair_type;

   // mirror of the buffer
   logic [KEY_W-1:0] key_store [DEPTH];
   logic [VAL_W-1:0] val_store [DEPTH];
   int               entries;
   logic             buffering;

   // pairs the block still owes on the result channel
   pair_type         owed_q [$];
   pair_type         oldest;

   initial begin
      fail_count = 0;
      pending    = 0;
      entries    = 0;
      buffering  = 1'b1;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // every buffered entry goes out in key order, last one marked
   task automatic drain_store();
      pair_type p;
      for (int i = 0; i < entries; i++) begin
         p.key   = key_store[i];
         p.value = val_store[i];
         p.last  = (i == entries - 1);
         owed_q.push_back(p);
      end
      entries = 0;
   endtask

   task automatic sorted_insert(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
      int pos;
      pos = entries;
      for (int i = 0; i < entries; i++) begin
         if (key_store[i] >= k) begin
            pos = i;
            break;
         end
      end
      // equal key only counts inside the valid range
      if (pos < entries && key_store[pos] == k) begin
         val_store[pos] = v;
      end else if (entries < DEPTH) begin
         for (int i = entries; i > pos; i--) begin
            key_store[i] = key_store[i-1];
            val_store[i] = val_store[i-1];
         end
         key_store[pos] = k;
         val_store[pos] = v;
         entries++;
      end
   endtask

   // expected pairs caused by one accepted request word
   task automatic apply_word(input logic cmd, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
      pair_type p;
      if (!buffering) begin
         // forward an insert, ignore a flush
         if (cmd == CMD_INSERT) begin
            p.key   = k;
            p.value = v;
            p.last  = 1'b1;
            owed_q.push_back(p);
         end
      end else if (cmd == CMD_FLUSH) begin
         drain_store();
      end else begin
         if (entries >= DEPTH)
            drain_store();
         sorted_insert(k, v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entries   = 0;
         buffering = 1'b1;
         owed_q.delete();
      end else begin
         // register write
         if (csr_valid && csr_ready)
            buffering = csr_buffer_enable;
         // compare a result word with the oldest owed pair
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               report_mismatch("unexpected result key", rsp_out_key, '0);
            end else begin
               oldest = owed_q.pop_front();
               if (rsp_out_key !== oldest.key)
                  report_mismatch("out_key", rsp_out_key, oldest.key);
               if (rsp_out_value !== oldest.value)
                  report_mismatch("out_value", rsp_out_value, oldest.value);
               if (rsp_last !== oldest.last)
                  report_mismatch("last", 64'(rsp_last), 64'(oldest.last));
            end
         end
         // accepted request word
         if (req_valid && req_ready)
            apply_word(req_cmd, req_key, req_value);
      end
      pending = owed_q.size();
   end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives the sorted write buffer with directed and random insert and flush
// words, random idling on both channels and one long result stall; the
// checker beside the block predicts every pair and counts mismatches
// ----------------------------------------------------------------------------
module testbench;
   import swb_pkg::*;

   localparam int  HOLD_CYCLES  = 300;
   localparam int  SETTLE       = 8;
   localparam real LIMIT_CYCLES = 1000000.0;

   logic             clock             = 1'b0;
   logic             reset             = 1'b1;
   logic             req_valid         = 1'b0;
   logic             req_ready;
   logic             req_cmd           = CMD_INSERT;
   logic [KEY_W-1:0] req_key           = '0;
   logic [VAL_W-1:0] req_value         = '0;
   logic             rsp_valid;
   logic             rsp_ready         = 1'b0;
   logic [KEY_W-1:0] rsp_out_key;
   logic [VAL_W-1:0] rsp_out_value;
   logic             rsp_last;
   logic             csr_valid         = 1'b0;
   logic             csr_ready;
   logic             csr_buffer_enable = 1'b0;

   int               fail_count;
   int               pending;
   bit               idle_on           = 1'b1;
   bit               hold_rsp          = 1'b0;

   always #5 clock = ~clock;

   sorted_write_buffer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_value     (rsp_out_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_buffer_enable (csr_buffer_enable)
   );

   swb_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_value     (rsp_out_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_buffer_enable (csr_buffer_enable),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, 13) : 0;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // pool keys collide often, wide keys cover every bit
   function automatic logic [KEY_W-1:0] pick_key(input bit wide);
      if (!wide)
         return KEY_W'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return KEY_W'($urandom_range(0, 40));
         4:       return ~KEY_W'($urandom_range(0, 40));
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return rand_word();
      endcase
   endfunction

   // offer one request word, return at the edge that takes it
   task automatic push_word(input logic cmd, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= k;
      req_value <= v;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic push_random(input bit wide, input int flush_odds);
      logic cmd;
      cmd = ($urandom_range(1, flush_odds) == 1) ? CMD_FLUSH : CMD_INSERT;
      push_word(cmd, pick_key(wide), pick_value());
   endtask

   // drop valid, wait until every owed pair is out, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_enable(input logic en);
      wait_idle();
      csr_valid         <= 1'b1;
      csr_buffer_enable <= en;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      repeat (SETTLE) @(posedge clock);
   endtask

   // result side: random stall per word, one long hold when asked
   initial begin
      int gap;
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid && !hold_rsp);
         @(posedge clock);
      end
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * 10.0);
      $display("sorted_write_buffer_top regression: fail");
      $finish;
   end

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // empty flush, extremes, equal keys at front, middle and back
      push_word(CMD_FLUSH, '1, '1);
      push_word(CMD_INSERT, '0, '1);
      push_word(CMD_INSERT, '1, '0);
      push_word(CMD_INSERT, 64'd5, 64'd1);
      push_word(CMD_INSERT, 64'd5, 64'd2);
      push_word(CMD_INSERT, '0, 64'd3);
      push_word(CMD_INSERT, '1, 64'd7);
      push_word(CMD_FLUSH, rand_word(), rand_word());
      push_word(CMD_FLUSH, '0, '0);
      // entries left behind while forwarding
      push_word(CMD_INSERT, 64'd10, 64'hAAAA_AAAA_AAAA_AAAA);
      push_word(CMD_INSERT, 64'd3, 64'h5555_5555_5555_5555);
      write_enable(1'b0);
      push_word(CMD_INSERT, '1, '1);
      push_word(CMD_INSERT, '0, '0);
      push_word(CMD_FLUSH, rand_word(), rand_word());
      push_word(CMD_INSERT, 64'd3, rand_word());
      write_enable(1'b1);
      push_word(CMD_FLUSH, '0, '0);

      // narrow keys, rare flush so the store fills and drains itself
      idle_on = 1'b1;
      repeat (101) push_random(1'b0, 50);

      // forwarding, no idling
      write_enable(1'b0);
      idle_on = 1'b0;
      repeat (60) push_random(1'b1, 4);

      // wide keys, frequent flush
      write_enable(1'b1);
      idle_on = 1'b1;
      repeat (100) push_random(1'b1, 10);

      // long result stall while the store fills and the request side backs up
      push_word(CMD_FLUSH, '0, '0);
      wait_idle();
      idle_on  = 1'b0;
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++)
         push_word(CMD_INSERT, {$urandom, 32'(100 - i)}, rand_word());
      push_word(CMD_FLUSH, '0, '0);
      wait_idle();

      // mixed tail
      idle_on = 1'b1;
      repeat (50) push_random(1'b1, 8);
      push_word(CMD_FLUSH, '0, '0);
      wait_idle();
      repeat (20) @(posedge clock);

      if (fail_count == 0)
         $display("sorted_write_buffer_top regression: pass");
      else
         $display("sorted_write_buffer_top regression: fail");
      $finish;
   end

endmodule
